// ===== rtl/core/u16u8_pkg.sv =====
package u16u8_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int MAX_BYTES  = 6;

    // register indexes, taken from paddr[2]
    localparam logic REG_WTF     = 1'b0;
    localparam logic REG_INVALID = 1'b1;

    // lone surrogate handling
    localparam logic [1:0] MODE_ABORT   = 2'd0;
    localparam logic [1:0] MODE_DROP    = 2'd1;
    localparam logic [1:0] MODE_REPLACE = 2'd2;
    localparam logic [1:0] MODE_LOWBYTE = 2'd3;

    localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
    localparam logic [20:0] SUPP_BASE        = 21'h10000;

    // a short run of bytes produced by one encoding step
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [3:0]      err;
        logic [2:0]      n;
        logic            ab;
        logic            hold;
    } seg_t;

    // all results of one item
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [MAX_BYTES-1:0]      err;
        logic [2:0]                n;
    } burst_t;

    typedef struct packed {
        logic [9:0] held_bits;
        logic       held_valid;
        logic       aborted;
    } state_t;

    function automatic seg_t err_seg();
        seg_t s;
        s        = '0;
        s.err[0] = 1'b1;
        s.n      = 3'd1;
        s.ab     = 1'b1;
        return s;
    endfunction

    function automatic seg_t put3(logic [15:0] u);
        seg_t s;
        s          = '0;
        s.bytes[0] = {4'hE, u[15:12]};
        s.bytes[1] = {2'b10, u[11:6]};
        s.bytes[2] = {2'b10, u[5:0]};
        s.n        = 3'd3;
        return s;
    endfunction

    function automatic seg_t pair_seg(logic [9:0] high, logic [9:0] low);
        seg_t        s;
        logic [20:0] cp;
        s          = '0;
        cp         = SUPP_BASE + {1'b0, high, low};
        s.bytes[0] = {5'b11110, cp[20:18]};
        s.bytes[1] = {2'b10, cp[17:12]};
        s.bytes[2] = {2'b10, cp[11:6]};
        s.bytes[3] = {2'b10, cp[5:0]};
        s.n        = 3'd4;
        return s;
    endfunction

    function automatic seg_t lone_seg(logic [15:0] u, logic wtf, logic [1:0] imode);
        seg_t s;
        s = '0;
        if (wtf)
        begin
            s = put3(u);
        end
        else
        begin
            case (imode)
                MODE_ABORT:   s = err_seg();
                MODE_DROP:    s = '0;
                MODE_REPLACE: s = put3(REPLACEMENT_CHAR);
                MODE_LOWBYTE:
                begin
                    if (u[15:8] == 8'hDC)
                    begin
                        s.bytes[0] = u[7:0];
                        s.n        = 3'd1;
                    end
                    else
                    begin
                        s = err_seg();
                    end
                end
                default:      s = err_seg();
            endcase
        end
        return s;
    endfunction

    function automatic seg_t unit_seg(logic [15:0] u, logic eot, logic wtf,
                                      logic [1:0] imode);
        seg_t s;
        s = '0;
        if (u[15:7] == 9'd0)
        begin
            s.bytes[0] = u[7:0];
            s.n        = 3'd1;
        end
        else if (u[15:11] == 5'd0)
        begin
            s.bytes[0] = {3'b110, u[10:6]};
            s.bytes[1] = {2'b10, u[5:0]};
            s.n        = 3'd2;
        end
        else if (u[15:11] == 5'b11011)
        begin
            // high surrogate waits for its partner unless the text ends here
            if (!u[10] && !eot)
                s.hold = 1'b1;
            else
                s = lone_seg(u, wtf, imode);
        end
        else
        begin
            s = put3(u);
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/utf16_to_utf8_converter.sv =====
// utf-16 to utf-8 converter
// slave stream: one utf-16 code unit per item in s_tdata, s_tlast marks the
// last unit of a text and flushes a pending high surrogate.
// master stream: one utf-8 byte per item in m_tdata; m_tuser high flags an
// error item (data zero); m_tlast marks the last byte caused by an input item.
// apb port: wtf_mode at 0x0, invalid_mode at 0x4, to be written by the user
// only while idle; the block does not enforce this. an accepted unit is
// registered in the input register, then the encoder turns it into up to
// six bytes that are loaded into the output shifter when it can take them.
// the output shifter sends one byte per cycle while m_tready is high; a unit
// yields 1 to 3 bytes, 4 for a pair or up to 6 after a lone surrogate, and
// a unit with no bytes or one byte leaves every cycle while m_tready holds.
// a stalled master holds the shifter, which fills the input register and then
// drops s_tready; nothing is lost.
// reset clears both configuration registers, the pending surrogate, the abort
// flag and both stages.
module utf16_to_utf8_converter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [u16u8_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [u16u8_pkg::APB_DATA_W-1:0] pwdata,
    output logic [u16u8_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // code_unit
    input  logic                             s_tlast,   // end_of_text
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // out_byte
    output logic                             m_tuser,   // status
    output logic                             m_tlast    // run_last
);
    import u16u8_pkg::*;

    logic        wtf_mode_reg;
    logic [1:0]  invalid_mode_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] in_unit_reg;
    logic        in_eot_reg;
    state_t      state_reg;
    state_t      state_next;
    burst_t      burst;
    logic        can_load;
    logic        consume;
    logic        s_take;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_INVALID) ? {30'd0, invalid_mode_reg}
                                                 : {31'd0, wtf_mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wtf_mode_reg     <= 1'b0;
            invalid_mode_reg <= MODE_ABORT;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_WTF)
                wtf_mode_reg <= pwdata[0];
            else
                invalid_mode_reg <= pwdata[1:0];
        end
    end

    assign consume  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (consume)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_unit_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    u16u8_encode u_encode (
        .code_unit    (in_unit_reg),
        .end_of_text  (in_eot_reg),
        .wtf_mode     (wtf_mode_reg),
        .invalid_mode (invalid_mode_reg),
        .st           (state_reg),
        .burst        (burst),
        .st_next      (state_next)
    );

    u16u8_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume),
        .burst    (burst),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_held_not_aborted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.held_valid |-> !state_reg.aborted)
        else $error("surrogate pending while aborted");

    a_err_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 8'h00))
        else $error("error item carries a nonzero byte");

    a_err_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("error item is not the last of its run");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_eot_reg) |=> (!state_reg.held_valid && !state_reg.aborted))
        else $error("end of text left state behind");
`endif

endmodule

// ===== rtl/core/u16u8_encode.sv =====
module u16u8_encode (
    input  logic [15:0]       code_unit,
    input  logic              end_of_text,
    input  logic              wtf_mode,
    input  logic [1:0]        invalid_mode,
    input  u16u8_pkg::state_t st,
    output u16u8_pkg::burst_t burst,
    output u16u8_pkg::state_t st_next
);
    import u16u8_pkg::*;

    seg_t       first;
    seg_t       second;
    seg_t       held_lone;
    seg_t       cur_unit;
    logic       is_low;
    logic       cfg_bad;
    logic       ab;
    logic       hold;
    logic [2:0] j;

    assign is_low    = (code_unit[15:10] == 6'b110111);
    assign cfg_bad   = wtf_mode && (invalid_mode == MODE_LOWBYTE);
    assign held_lone = lone_seg({6'b110110, st.held_bits}, wtf_mode, invalid_mode);
    assign cur_unit  = unit_seg(code_unit, end_of_text, wtf_mode, invalid_mode);

    always_comb
    begin
        first  = '0;
        second = '0;
        if (st.aborted)
        begin
            first = '0;
        end
        else if (cfg_bad)
        begin
            first = err_seg();
        end
        else if (st.held_valid)
        begin
            if (is_low)
            begin
                first = pair_seg(st.held_bits, code_unit[9:0]);
            end
            else
            begin
                first = held_lone;
                if (!held_lone.ab)
                    second = cur_unit;
            end
        end
        else
        begin
            first = cur_unit;
        end
    end

    assign ab   = first.ab | second.ab;
    assign hold = first.hold | second.hold;

    // append the second run right behind the first
    always_comb
    begin
        burst   = '0;
        burst.n = first.n + second.n;
        j       = '0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            j = 3'(i) - first.n;
            if (3'(i) < first.n)
            begin
                burst.bytes[i] = first.bytes[2'(i)];
                burst.err[i]   = first.err[2'(i)];
            end
            else if (j < second.n)
            begin
                burst.bytes[i] = second.bytes[j[1:0]];
                burst.err[i]   = second.err[j[1:0]];
            end
        end
    end

    always_comb
    begin
        st_next = st;
        if (!st.aborted && !cfg_bad && st.held_valid)
            st_next.held_valid = 1'b0;
        if (!st.aborted && hold)
        begin
            st_next.held_bits  = code_unit[9:0];
            st_next.held_valid = 1'b1;
        end
        if (ab)
        begin
            st_next.aborted    = 1'b1;
            st_next.held_valid = 1'b0;
            st_next.held_bits  = '0;
        end
        if (end_of_text)
            st_next = '0;
    end

endmodule

// ===== rtl/core/u16u8_serializer.sv =====
module u16u8_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  u16u8_pkg::burst_t burst,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic              m_tuser,   // status
    output logic              m_tlast    // run_last
);
    import u16u8_pkg::*;

    logic [MAX_BYTES-1:0][7:0] byte_reg;
    logic [MAX_BYTES-1:0][7:0] byte_next;
    logic [MAX_BYTES-1:0]      err_reg;
    logic [MAX_BYTES-1:0]      err_next;
    logic [2:0]                rem_reg;
    logic [2:0]                rem_next;
    logic                      take;

    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tlast  = (rem_reg == 3'd1);
    assign m_tdata  = byte_reg[0];
    assign m_tuser  = err_reg[0];
    assign take     = m_tvalid && m_tready;
    assign can_load = !m_tvalid || (m_tlast && m_tready);

    always_comb
    begin
        byte_next = byte_reg;
        err_next  = err_reg;
        rem_next  = rem_reg;
        if (load)
        begin
            byte_next = burst.bytes;
            err_next  = burst.err;
            rem_next  = burst.n;
        end
        else if (take)
        begin
            // next byte moves to the head
            byte_next = {8'h00, byte_reg[MAX_BYTES-1:1]};
            err_next  = {1'b0, err_reg[MAX_BYTES-1:1]};
            rem_next  = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        err_reg  <= err_next;
    end

endmodule
